### src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet during reset
`define CHK_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("chk");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("chk");
`endif

### src/ptt_pkg.sv
// Package: commands, result kinds and controller interface types
package ptt_pkg;
  typedef enum logic [3:0] {
    CMD_TICK = 4'd0, CMD_ADD_PER = 4'd1, CMD_ADD_SHOT = 4'd2, CMD_ENABLE = 4'd3,
    CMD_QUERY = 4'd4, CMD_RESTART = 4'd5, CMD_SET_INT = 4'd6, CMD_REM_PER = 4'd7,
    CMD_ABORT = 4'd8, CMD_READ_TIME = 4'd9
  } cmd_t;
  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0, KIND_PER = 2'd1, KIND_SHOT = 2'd2, KIND_DONE = 2'd3
  } kind_t;
  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item
    logic clr;      // clear walk index
    logic step;     // process slot at walk index, advance
    logic reply;    // emit command reply
    logic done;     // emit tick done
    logic shot_ph;  // walk in one-shot table
  } dp_cmd_t;
  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic per_end;
    logic shot_end;
  } dp_sts_t;
endpackage

### src/ptt_ctrl.sv
// Controller: sequences slot walks and result emission
module ptt_ctrl import ptt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_PER, S_SHOT, S_DONE, S_REPLY} state_t;
  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else begin
      case (state_r)
        S_IDLE:  if (start) state_r <= S_DEC;
        S_DEC:   state_r <= sts.is_tick ? S_PER : S_REPLY;
        S_PER:   if (sts.per_end) state_r <= S_SHOT;
        S_SHOT:  if (sts.shot_end) state_r <= S_DONE;
        S_DONE:  state_r <= S_IDLE;
        S_REPLY: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  always_comb begin
    cmd = '0;
    cmd.load    = (state_r == S_IDLE) && start;
    cmd.clr     = (state_r == S_DEC) || (state_r == S_PER && sts.per_end);
    cmd.step    = (state_r == S_PER) || (state_r == S_SHOT) || (state_r == S_REPLY);
    cmd.shot_ph = (state_r == S_SHOT);
    cmd.reply   = (state_r == S_REPLY);
    cmd.done    = (state_r == S_DONE);
  end
endmodule

### src/ptt_dp.sv
// Datapath: slot tables, counters, lookup and result registers
module ptt_dp import ptt_pkg::*; #(
  parameter int PERIODIC_SLOTS = 8,
  parameter int ONESHOT_SLOTS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [3:0]  in_cmd,
  input  logic [15:0] in_task_id,
  input  logic [31:0] in_period_or_delay,
  input  logic        in_enable_flag,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_result_id,
  output logic        out_ok,
  output logic [31:0] out_time_now,
  output logic        out_last
);
  localparam int PW = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
  localparam int SW = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
  localparam int IW = (PW > SW) ? PW : SW;

  logic [15:0] per_id_r [PERIODIC_SLOTS];
  logic [31:0] per_limit_r [PERIODIC_SLOTS];
  logic [31:0] per_count_r [PERIODIC_SLOTS];
  logic        per_en_r [PERIODIC_SLOTS];
  logic [15:0] shot_id_r [ONESHOT_SLOTS];
  logic [31:0] shot_rem_r [ONESHOT_SLOTS];
  logic [15:0] id_ctr_r;
  logic [31:0] millis_r;
  logic [3:0]  cmd_r;
  logic [15:0] tid_r;
  logic [31:0] val_r;
  logic        en_r;
  logic [IW:0] idx_r;
  logic        hit_r;  // found a slot already during this walk

  logic [PW-1:0] pi;
  logic [SW-1:0] si;
  logic [31:0]   lim_nxt;
  logic [15:0]   id_nxt;
  logic          ok_nxt;
  logic [15:0]   rid_nxt;
  logic          p_match, s_match;

  assign pi = idx_r[PW-1:0];
  assign si = idx_r[SW-1:0];
  assign lim_nxt = (val_r == 32'd0) ? 32'd0 : val_r - 32'd1;
  assign id_nxt = (id_ctr_r == 16'hFFFF) ? 16'd1 : id_ctr_r + 16'd1;
  assign sts.is_tick  = (cmd_r == CMD_TICK);
  assign sts.per_end  = (idx_r == (IW+1)'(PERIODIC_SLOTS - 1));
  assign sts.shot_end = (idx_r == (IW+1)'(ONESHOT_SLOTS - 1));
  assign p_match = (tid_r != 16'd0) && (per_id_r[pi] == tid_r) && !hit_r;
  assign s_match = (tid_r != 16'd0) && (shot_id_r[si] == tid_r) && !hit_r;

  // reply: combinational compare across both tables in the reply state
  always_comb begin
    ok_nxt = 1'b0;
    rid_nxt = 16'd0;
    for (int i = PERIODIC_SLOTS - 1; i >= 0; i--) begin
      if (cmd_r == CMD_ADD_PER && per_id_r[i] == 16'd0) begin
        ok_nxt = 1'b1; rid_nxt = id_ctr_r;
      end
    end
    for (int i = ONESHOT_SLOTS - 1; i >= 0; i--) begin
      if (cmd_r == CMD_ADD_SHOT && shot_id_r[i] == 16'd0) begin
        ok_nxt = 1'b1; rid_nxt = id_ctr_r;
      end
    end
    case (cmd_r)
      CMD_ENABLE, CMD_RESTART, CMD_SET_INT, CMD_REM_PER, CMD_QUERY: begin
        for (int i = PERIODIC_SLOTS - 1; i >= 0; i--) begin
          if (tid_r != 16'd0 && per_id_r[i] == tid_r)
            ok_nxt = (cmd_r == CMD_QUERY) ? per_en_r[i] : 1'b1;
        end
      end
      CMD_ABORT: begin
        for (int i = 0; i < ONESHOT_SLOTS; i++) begin
          if (tid_r != 16'd0 && shot_id_r[i] == tid_r) ok_nxt = 1'b1;
        end
      end
      CMD_READ_TIME: ok_nxt = 1'b1;
      default: ;
    endcase
  end

  logic [PERIODIC_SLOTS-1:0] p_first;
  logic [ONESHOT_SLOTS-1:0]  s_first;
  always_comb begin
    p_first = '0;
    s_first = '0;
    for (int i = PERIODIC_SLOTS - 1; i >= 0; i--) begin
      if ((cmd_r == CMD_ADD_PER) ? (per_id_r[i] == 16'd0)
          : (tid_r != 16'd0 && per_id_r[i] == tid_r)) begin
        p_first = '0; p_first[i] = 1'b1;
      end
    end
    for (int i = ONESHOT_SLOTS - 1; i >= 0; i--) begin
      if ((cmd_r == CMD_ADD_SHOT) ? (shot_id_r[i] == 16'd0)
          : (tid_r != 16'd0 && shot_id_r[i] == tid_r)) begin
        s_first = '0; s_first[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PERIODIC_SLOTS; i++) begin
        per_id_r[i] <= '0; per_limit_r[i] <= '0; per_count_r[i] <= '0; per_en_r[i] <= 1'b0;
      end
      for (int i = 0; i < ONESHOT_SLOTS; i++) begin
        shot_id_r[i] <= '0; shot_rem_r[i] <= '0;
      end
      id_ctr_r <= 16'd1;
      millis_r <= '0;
      idx_r <= '0;
      hit_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.load) begin
        cmd_r <= in_cmd; tid_r <= in_task_id; val_r <= in_period_or_delay;
        en_r <= in_enable_flag;
        if (in_cmd == CMD_TICK) millis_r <= millis_r + 32'd1;
      end
      if (cmd.clr) begin
        idx_r <= '0; hit_r <= 1'b0;
      end else if (cmd.step && !cmd.reply) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.step && !cmd.reply && !cmd.shot_ph && per_id_r[pi] != 16'd0) begin
        if (per_count_r[pi] >= per_limit_r[pi]) begin
          per_count_r[pi] <= '0;
          if (per_en_r[pi]) begin
            out_valid <= 1'b1; out_kind <= KIND_PER; out_result_id <= per_id_r[pi];
            out_ok <= 1'b1; out_time_now <= millis_r; out_last <= 1'b0;
          end
        end else per_count_r[pi] <= per_count_r[pi] + 32'd1;
      end
      if (cmd.step && cmd.shot_ph && shot_id_r[si] != 16'd0) begin
        if (shot_rem_r[si] == 32'd0) begin
          shot_id_r[si] <= '0;
          out_valid <= 1'b1; out_kind <= KIND_SHOT; out_result_id <= shot_id_r[si];
          out_ok <= 1'b1; out_time_now <= millis_r; out_last <= 1'b0;
        end else shot_rem_r[si] <= shot_rem_r[si] - 32'd1;
      end
      if (cmd.done) begin
        out_valid <= 1'b1; out_kind <= KIND_DONE; out_result_id <= '0;
        out_ok <= 1'b1; out_time_now <= millis_r; out_last <= 1'b1;
      end
      if (cmd.reply) begin
        out_valid <= 1'b1; out_kind <= KIND_REPLY; out_result_id <= rid_nxt;
        out_ok <= ok_nxt; out_time_now <= millis_r; out_last <= 1'b1;
        for (int i = 0; i < PERIODIC_SLOTS; i++) begin
          if (p_first[i]) begin
            case (cmd_r)
              CMD_ADD_PER: begin
                per_count_r[i] <= '0; per_limit_r[i] <= lim_nxt; per_en_r[i] <= 1'b1;
                per_id_r[i] <= id_ctr_r;
              end
              CMD_ENABLE:  per_en_r[i] <= en_r;
              CMD_RESTART: per_count_r[i] <= '0;
              CMD_SET_INT: per_limit_r[i] <= lim_nxt;
              CMD_REM_PER: per_id_r[i] <= '0;
              default: ;
            endcase
          end
        end
        for (int i = 0; i < ONESHOT_SLOTS; i++) begin
          if (s_first[i]) begin
            case (cmd_r)
              CMD_ADD_SHOT: begin
                shot_rem_r[i] <= val_r; shot_id_r[i] <= id_ctr_r;
              end
              CMD_ABORT: shot_id_r[i] <= '0;
              default: ;
            endcase
          end
        end
        if ((cmd_r == CMD_ADD_PER && |p_first) || (cmd_r == CMD_ADD_SHOT && |s_first))
          id_ctr_r <= id_nxt;
      end
      if (cmd.step && !cmd.reply && (p_match || s_match)) hit_r <= 1'b1;
    end
  end
endmodule

### src/periodic_and_oneshot_timer_table_core.sv
// Top level: timer table core, controller plus datapath
// A tick walks every periodic slot then every one-shot slot, one slot per
// cycle, and gives one result per firing slot plus a done result. Any other
// command gives one reply. busy rises the cycle after acceptance and drops
// in the cycle the last result shows; each result shows on out_* for one
// cycle with out_valid and cannot be stalled.
module periodic_and_oneshot_timer_table_core import ptt_pkg::*; #(
  parameter int PERIODIC_SLOTS = 8,
  parameter int ONESHOT_SLOTS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_cmd,
  input  logic [15:0] in_task_id,
  input  logic [31:0] in_period_or_delay,
  input  logic        in_enable_flag,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_result_id,
  output logic        out_ok,
  output logic [31:0] out_time_now,
  output logic        out_last
);
  dp_cmd_t dcmd;
  dp_sts_t dsts;

  ptt_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts(dsts), .cmd(dcmd));

  ptt_dp #(.PERIODIC_SLOTS(PERIODIC_SLOTS), .ONESHOT_SLOTS(ONESHOT_SLOTS)) u_dp (
    .clk, .rst_n, .cmd(dcmd), .sts(dsts), .in_cmd, .in_task_id, .in_period_or_delay,
    .in_enable_flag, .out_valid, .out_kind, .out_result_id, .out_ok, .out_time_now,
    .out_last
  );
endmodule

### src/ptt_checker.sv
// Port-level checker for the timer table core, with bind
`include "assert_macros.svh"
module ptt_checker import ptt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic       out_ok,
  input logic       out_last
);
  `CHK_IMPL(a_res_busy, clk, rst_n, out_valid && !out_last, busy)
  `CHK_IMPL(a_last_idle, clk, rst_n, out_valid && out_last, !busy)
  `CHK_IMPL(a_fire_ok, clk, rst_n, out_valid && out_kind != KIND_REPLY, out_ok)
  `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
endmodule

bind periodic_and_oneshot_timer_table_core ptt_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_kind, .out_ok, .out_last
);
